[rtl/lffa_pkg.sv]
package lffa_pkg;

   // Pool geometry.
   localparam int NUM_FRAMES = 4096;
   localparam int PAGE_BITS  = 12;

   localparam int FIDX_W    = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
   localparam int WORD_BITS = (FIDX_W >= 6) ? 64 : (1 << FIDX_W);
   localparam int BIDX_W    = $clog2(WORD_BITS);
   localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int NCNT_W    = $clog2(NUM_FRAMES + 1);

   // Register file.
   localparam int BASE_W  = 20;
   localparam int COUNT_W = 13;
   localparam int PADDR_W = 3;
   localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(4096);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);
   localparam logic REG_USER_BASE   = 1'b0;
   localparam logic REG_FRAME_COUNT = 1'b1;

   // Commands and status codes.
   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FAIL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] address;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] frame_address;
   } rsp_payload_type;

   typedef struct packed {
      logic [BASE_W-1:0]  user_base_frame;
      logic [COUNT_W-1:0] pool_size;
   } cfg_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WIDX_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [WIDX_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] rd_data;
      logic                 any_free;
      logic [WIDX_W-1:0]    low_word;
   } map_rsp_type;

endpackage

[rtl/lffa_csr.sv]
module lffa_csr
   import lffa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [BASE_W-1:0]  base_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               wr_en;

   // Registers sit every four bytes, so the word index is the upper address bit.
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         count_ff <= COUNT_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_USER_BASE) begin
            base_ff <= pwdata[BASE_W-1:0];
         end else begin
            count_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_FRAME_COUNT) begin
         prdata = 32'(count_ff);
      end else begin
         prdata = 32'(base_ff);
      end
   end

   assign cfg.user_base_frame = base_ff;
   assign cfg.pool_size       = count_ff;

endmodule

[rtl/lffa_map.sv]
module lffa_map
   import lffa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  map_req_type map_req,
   output map_rsp_type map_rsp
);

   logic [WORD_BITS-1:0] map_mem_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [NUM_WORDS-1:0] valid_ff;
   logic [NUM_WORDS-1:0] summ_ff;
   logic [WIDX_W-1:0]    low_word;

   // Bitmap words; no reset, a word that was never written reads as empty.
   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         map_mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= map_mem_ff[map_req.rd_addr];
      end
   end

   // Per-word valid bits and the non-empty summary.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         summ_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (map_req.rd_en) begin
            rd_vld_ff <= valid_ff[map_req.rd_addr];
         end
         if (map_req.wr_en) begin
            valid_ff[map_req.wr_addr] <= 1'b1;
            summ_ff[map_req.wr_addr]  <= |map_req.wr_data;
         end
      end
   end

   always_comb begin
      low_word = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (summ_ff[i]) begin
            low_word = WIDX_W'(i);
         end
      end
   end

   assign map_rsp.rd_data  = rd_vld_ff ? rd_data_ff : '0;
   assign map_rsp.any_free = |summ_ff;
   assign map_rsp.low_word = low_word;

endmodule

[rtl/lowest_first_frame_allocator.sv]
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      req_payload (command, address)
// result    out        rsp_valid high for one cycle   rsp_payload (status, frame_address)
// config    in         psel/penable/pwrite, pready=1  pwdata to register paddr[2]
//
// An allocate does a summary search and word read, then a bit clear and
// write-back; a free reads and then writes back its word, or answers from idle
// when the frame is ignored or out of range, as does any failing command. Init
// walks the bitmap memory's single read and write port, reading and writing back
// each 64-frame word it touches. Reset is synchronous; it empties the pool at
// once through per-word valid bits, so no clearing pass follows. The receiver
// cannot stall: each result stands for one cycle, and busy only covers the work.
module lowest_first_frame_allocator
   import lffa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_payload_type    req_payload,
   output logic               rsp_valid,
   output rsp_payload_type    rsp_payload,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE,
      S_INIT_WR,
      S_INIT_RD
   } state_type;

   cfg_type         cfg;
   map_req_type     map_req;
   map_rsp_type     map_rsp;

   state_type       state_ff, state_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic [WIDX_W-1:0] last_ff, last_in;
   logic [BIDX_W-1:0] bit_ff, bit_in;
   logic [NCNT_W-1:0] n_ff, n_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [31:0]          base32;
   logic [31:0]          count32;
   logic [31:0]          n32;
   logic [31:0]          page32;
   logic [31:0]          idx32;
   logic                 free_ignore;
   logic                 free_range;
   logic [BIDX_W-1:0]    low_bit;
   logic [31:0]          frame32;
   logic [31:0]          rem32;
   logic [WORD_BITS-1:0] init_mask;

   lffa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lffa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .map_rsp (map_rsp)
   );

   // The frame count is saturated to the bitmap capacity when init uses it.
   assign base32  = 32'(cfg.user_base_frame);
   assign count32 = 32'(cfg.pool_size);
   assign n32     = (count32 > 32'(NUM_FRAMES)) ? 32'(NUM_FRAMES) : count32;

   // Free: the page number relative to the base. The base frame itself and
   // anything below it are dropped with an OK status; past the bitmap is flagged.
   assign page32      = req_payload.address >> PAGE_BITS;
   assign idx32       = page32 - base32;
   assign free_ignore = (page32 <= base32);
   assign free_range  = (idx32 >= 32'(NUM_FRAMES));

   // Lowest set bit of the word that has just been read.
   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (map_rsp.rd_data[i]) begin
            low_bit = BIDX_W'(i);
         end
      end
   end

   // The address wraps at 32 bits when base plus index shifted up overflows.
   assign frame32 = base32 + ((32'(word_ff) << BIDX_W) | 32'(low_bit));

   // Init mask for the current word: frames below the count, never the zero frame.
   assign rem32 = 32'(n_ff) - (32'(word_ff) << BIDX_W);
   always_comb begin
      if (rem32 >= 32'(WORD_BITS)) begin
         init_mask = '1;
      end else begin
         init_mask = ~({WORD_BITS{1'b1}} << rem32[BIDX_W-1:0]);
      end
      if (word_ff == '0) begin
         init_mask[0] = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      bit_in       = bit_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.status        = ST_OK;
               rsp_in.frame_address = '0;
               case (req_payload.command)
                  CMD_INIT: begin
                     if (n32 == '0) begin
                        rsp_in.status = ST_FAIL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        n_in            = NCNT_W'(n32);
                        last_in         = WIDX_W'((n32 - 32'd1) >> BIDX_W);
                        word_in         = '0;
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = '0;
                        state_in        = S_INIT_WR;
                     end
                  end
                  CMD_ALLOC: begin
                     if (!map_rsp.any_free) begin
                        rsp_in.status = ST_FAIL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        word_in         = map_rsp.low_word;
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = map_rsp.low_word;
                        state_in        = S_ALLOC;
                     end
                  end
                  CMD_FREE: begin
                     if (free_ignore) begin
                        rsp_valid_in = 1'b1;
                     end else if (free_range) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        word_in         = WIDX_W'(idx32 >> BIDX_W);
                        bit_in          = idx32[BIDX_W-1:0];
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = WIDX_W'(idx32 >> BIDX_W);
                        state_in        = S_FREE;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_FAIL;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            map_req.wr_en        = 1'b1;
            map_req.wr_addr      = word_ff;
            map_req.wr_data      = map_rsp.rd_data & ~(WORD_BITS'(1) << low_bit);
            rsp_in.status        = ST_OK;
            rsp_in.frame_address = frame32 << PAGE_BITS;
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         S_FREE: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = word_ff;
            map_req.wr_data = map_rsp.rd_data | (WORD_BITS'(1) << bit_ff);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         S_INIT_WR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = word_ff;
            map_req.wr_data = map_rsp.rd_data | init_mask;
            if (word_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_INIT_RD;
            end
         end
         S_INIT_RD: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = word_ff;
            state_in        = S_INIT_WR;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      last_ff <= last_in;
      bit_ff  <= bit_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
